/* hw/rtl/kcl_pkg.sv */
// Shared constants, codes and character tables for the keypad code lock.
package kcl_pkg;

    typedef logic [7:0] t_char;

    localparam int KCL_PIN_DIGITS = 4;
    localparam int KCL_LINE_MAX   = 48;

    localparam int TIMER_W = 13;
    localparam int LEN_W   = 6;
    localparam int PREFIX_LEN = 8;

    localparam logic [TIMER_W-1:0] TIMER_MAX = 13'd8191;
    localparam logic [LEN_W-1:0]   LEN_MAX   = 6'd63;

    localparam logic [TIMER_W-1:0] RST_INPUT_TIMEOUT = 13'd5000;
    localparam logic [TIMER_W-1:0] RST_ACCESS_TIME   = 13'd3000;
    localparam logic [TIMER_W-1:0] RST_BLINK_HALF    = 13'd250;

    // lock modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_AWAIT  = 2'd1;
    localparam logic [1:0] MODE_ACCESS = 2'd2;

    // item kinds
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_BUTTON = 2'd1;
    localparam logic [1:0] ACT_KEY    = 2'd2;
    localparam logic [1:0] ACT_SERIAL = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_INPUT_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_ACCESS_TIME   = 2'd1;
    localparam logic [1:0] CFG_BLINK_HALF    = 2'd2;

    // serial parser phases
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_OLD    = 2'd1;
    localparam logic [1:0] PH_NEW    = 2'd2;

    // event codes
    localparam logic [3:0] EV_NONE         = 4'd0;
    localparam logic [3:0] EV_AWAIT        = 4'd1;
    localparam logic [3:0] EV_TIMEOUT      = 4'd2;
    localparam logic [3:0] EV_WRONG_PIN    = 4'd3;
    localparam logic [3:0] EV_GRANTED      = 4'd4;
    localparam logic [3:0] EV_SESSION_END  = 4'd5;
    localparam logic [3:0] EV_PIN_UPDATED  = 4'd6;
    localparam logic [3:0] EV_NOT_IDLE     = 4'd7;
    localparam logic [3:0] EV_UNKNOWN_CMD  = 4'd8;
    localparam logic [3:0] EV_BAD_FORMAT   = 4'd9;
    localparam logic [3:0] EV_WRONG_LENGTH = 4'd10;
    localparam logic [3:0] EV_OLD_PIN_BAD  = 4'd11;
    localparam logic [3:0] EV_LINE_LONG    = 4'd12;

    localparam t_char CH_CR   = 8'h0D;
    localparam t_char CH_LF   = 8'h0A;
    localparam t_char CH_SEMI = 8'h3B;

    // "NEW PIN;"
    function automatic t_char prefix_char(input logic [2:0] idx);
        t_char c;
        case (idx)
            3'd0:    c = 8'h4E;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h57;
            3'd3:    c = 8'h20;
            3'd4:    c = 8'h50;
            3'd5:    c = 8'h49;
            3'd6:    c = 8'h4E;
            default: c = 8'h3B;
        endcase
        return c;
    endfunction

    // factory PIN "1772", repeated for longer PINs
    function automatic t_char default_pin_char(input logic [1:0] idx);
        t_char c;
        case (idx)
            2'd0:    c = 8'h31;
            2'd1:    c = 8'h37;
            2'd2:    c = 8'h37;
            default: c = 8'h32;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/keypad_code_lock_unit.sv */
// Keypad code lock: mode control, PIN check, timers and serial PIN-change parser.
// Takes one item per clock cycle with no gaps while the output takes results: an
// accepted item lands in an input register, then, once the output is free, one pass of
// compare/increment logic updates the lock state and loads the result register.
// The rate is set by that single state-update pass; the result register lets a new
// item enter while the previous result still waits on the output. Reset needs no
// clearing pass; the factory PIN "1772" is loaded by reset itself.
module keypad_code_lock_unit
    import kcl_pkg::*;
#(
    parameter int PIN_DIGITS = KCL_PIN_DIGITS,
    parameter int LINE_MAX   = KCL_LINE_MAX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [TIMER_W-1:0] i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // key_char[7:0], rx_byte[15:8]
    input  logic [1:0]         s_axis_tuser,   // action[1:0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata    // lock_mode_out[1:0], red_light[2],
                                               // green_light[3], key_flash[4],
                                               // event_code[8:5], zero[15:9]
);

    localparam int DC_W = $clog2(PIN_DIGITS + 1);
    localparam logic [LEN_W-1:0] LINE_LAST = LEN_W'(LINE_MAX - 1);
    localparam logic [LEN_W-1:0] PIN_LEN   = LEN_W'(PIN_DIGITS);
    localparam logic [DC_W-1:0]  DC_LAST   = DC_W'(PIN_DIGITS - 1);

    // configuration
    logic [TIMER_W-1:0] r_input_timeout, r_access_time, r_blink_half;

    // input stage
    logic       r_in_valid;
    logic [1:0] r_in_action;
    t_char      r_in_key, r_in_rx;

    // output stage
    logic        r_out_valid;
    logic [8:0]  r_out_data;

    // lock state
    logic [1:0]         r_lock_mode,   n_lock_mode;
    logic [TIMER_W-1:0] r_mode_timer,  n_mode_timer;
    logic [TIMER_W-1:0] r_blink_timer, n_blink_timer;
    logic               r_red_phase,   n_red_phase;
    logic [DC_W-1:0]    r_digit_count, n_digit_count;
    t_char              r_entered [PIN_DIGITS];
    t_char              n_entered [PIN_DIGITS];
    t_char              r_stored_pin [PIN_DIGITS];
    t_char              n_stored_pin [PIN_DIGITS];

    // parser state
    logic [LEN_W-1:0]   r_line_length, n_line_length;
    logic [1:0]         r_parse_phase, n_parse_phase;
    logic               r_prefix_ok,   n_prefix_ok;
    logic [LEN_W-1:0]   r_old_length,  n_old_length;
    logic               r_old_matches, n_old_matches;
    logic [LEN_W-1:0]   r_new_length,  n_new_length;
    t_char              r_new_digits [PIN_DIGITS];
    t_char              n_new_digits [PIN_DIGITS];

    logic       w_adv;
    logic       n_flash;
    logic [3:0] n_event;
    logic       w_same;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_timeout <= RST_INPUT_TIMEOUT;
            r_access_time   <= RST_ACCESS_TIME;
            r_blink_half    <= RST_BLINK_HALF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INPUT_TIMEOUT: r_input_timeout <= i_cfg_data;
                CFG_ACCESS_TIME:   r_access_time   <= i_cfg_data;
                CFG_BLINK_HALF:    r_blink_half    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_key    <= s_axis_tdata[7:0];
            r_in_rx     <= s_axis_tdata[15:8];
        end
    end

    // full-PIN check: slots already held plus the key arriving now in the last slot
    always_comb begin
        w_same = 1'b1;
        for (int i = 0; i < PIN_DIGITS; i++) begin
            if (i == PIN_DIGITS - 1) begin
                if (r_in_key != r_stored_pin[i]) w_same = 1'b0;
            end else begin
                if (r_entered[i] != r_stored_pin[i]) w_same = 1'b0;
            end
        end
    end

    always_comb begin
        n_lock_mode   = r_lock_mode;
        n_mode_timer  = r_mode_timer;
        n_blink_timer = r_blink_timer;
        n_red_phase   = r_red_phase;
        n_digit_count = r_digit_count;
        n_entered     = r_entered;
        n_stored_pin  = r_stored_pin;
        n_line_length = r_line_length;
        n_parse_phase = r_parse_phase;
        n_prefix_ok   = r_prefix_ok;
        n_old_length  = r_old_length;
        n_old_matches = r_old_matches;
        n_new_length  = r_new_length;
        n_new_digits  = r_new_digits;
        n_flash       = 1'b0;
        n_event       = EV_NONE;

        case (r_in_action)
            ACT_TICK: begin
                if (r_lock_mode == MODE_AWAIT) begin
                    n_mode_timer  = (r_mode_timer == TIMER_MAX) ? TIMER_MAX
                                  : r_mode_timer + TIMER_W'(1);
                    n_blink_timer = (r_blink_timer == TIMER_MAX) ? TIMER_MAX
                                  : r_blink_timer + TIMER_W'(1);
                    if (n_blink_timer >= r_blink_half) begin
                        n_blink_timer = '0;
                        n_red_phase   = !r_red_phase;
                    end
                    if (n_mode_timer >= r_input_timeout) begin
                        n_lock_mode   = MODE_IDLE;
                        n_mode_timer  = '0;
                        n_blink_timer = '0;
                        n_digit_count = '0;
                        n_red_phase   = 1'b1;
                        n_event       = EV_TIMEOUT;
                    end
                end else if (r_lock_mode == MODE_ACCESS) begin
                    n_mode_timer = (r_mode_timer == TIMER_MAX) ? TIMER_MAX
                                 : r_mode_timer + TIMER_W'(1);
                    if (n_mode_timer >= r_access_time) begin
                        n_lock_mode   = MODE_IDLE;
                        n_mode_timer  = '0;
                        n_blink_timer = '0;
                        n_digit_count = '0;
                        n_red_phase   = 1'b1;
                        n_event       = EV_SESSION_END;
                    end
                end
            end
            ACT_BUTTON: begin
                if (r_lock_mode == MODE_IDLE) begin
                    n_lock_mode   = MODE_AWAIT;
                    n_mode_timer  = '0;
                    n_blink_timer = '0;
                    n_digit_count = '0;
                    n_red_phase   = 1'b1;
                    n_event       = EV_AWAIT;
                end
            end
            ACT_KEY: begin
                if (r_lock_mode == MODE_AWAIT) begin
                    n_flash = 1'b1;
                    for (int i = 0; i < PIN_DIGITS; i++) begin
                        if (r_digit_count == DC_W'(i)) n_entered[i] = r_in_key;
                    end
                    n_digit_count = r_digit_count + DC_W'(1);
                    if (r_digit_count >= DC_LAST) begin
                        n_mode_timer  = '0;
                        n_blink_timer = '0;
                        n_digit_count = '0;
                        if (w_same) begin
                            n_lock_mode = MODE_ACCESS;
                            n_red_phase = 1'b0;
                            n_event     = EV_GRANTED;
                        end else begin
                            n_lock_mode = MODE_IDLE;
                            n_red_phase = 1'b1;
                            n_event     = EV_WRONG_PIN;
                        end
                    end
                end
            end
            default: begin
                if (r_in_rx == CH_CR || r_in_rx == CH_LF) begin
                    if (r_line_length != '0) begin
                        // checks run in priority order
                        if (r_lock_mode != MODE_IDLE) begin
                            n_event = EV_NOT_IDLE;
                        end else if (r_parse_phase == PH_PREFIX || !r_prefix_ok) begin
                            n_event = EV_UNKNOWN_CMD;
                        end else if (r_parse_phase != PH_NEW) begin
                            n_event = EV_BAD_FORMAT;
                        end else if (r_old_length != PIN_LEN || r_new_length != PIN_LEN) begin
                            n_event = EV_WRONG_LENGTH;
                        end else if (!r_old_matches) begin
                            n_event = EV_OLD_PIN_BAD;
                        end else begin
                            n_stored_pin = r_new_digits;
                            n_event      = EV_PIN_UPDATED;
                        end
                        n_line_length = '0;
                        n_parse_phase = PH_PREFIX;
                        n_prefix_ok   = 1'b1;
                        n_old_length  = '0;
                        n_old_matches = 1'b1;
                        n_new_length  = '0;
                    end
                end else if (r_line_length >= LINE_LAST) begin
                    n_line_length = '0;
                    n_parse_phase = PH_PREFIX;
                    n_prefix_ok   = 1'b1;
                    n_old_length  = '0;
                    n_old_matches = 1'b1;
                    n_new_length  = '0;
                    n_event       = EV_LINE_LONG;
                end else begin
                    if (r_parse_phase == PH_PREFIX) begin
                        if (r_in_rx != prefix_char(r_line_length[2:0])) n_prefix_ok = 1'b0;
                        if (r_line_length >= LEN_W'(PREFIX_LEN - 1)) n_parse_phase = PH_OLD;
                    end else if (r_parse_phase == PH_OLD) begin
                        if (r_in_rx == CH_SEMI) begin
                            n_parse_phase = PH_NEW;
                        end else begin
                            for (int i = 0; i < PIN_DIGITS; i++) begin
                                if (r_old_length == LEN_W'(i) && r_in_rx != r_stored_pin[i])
                                    n_old_matches = 1'b0;
                            end
                            n_old_length = (r_old_length == LEN_MAX) ? LEN_MAX
                                         : r_old_length + LEN_W'(1);
                        end
                    end else begin
                        for (int i = 0; i < PIN_DIGITS; i++) begin
                            if (r_new_length == LEN_W'(i)) n_new_digits[i] = r_in_rx;
                        end
                        n_new_length = (r_new_length == LEN_MAX) ? LEN_MAX
                                     : r_new_length + LEN_W'(1);
                    end
                    n_line_length = (r_line_length == LEN_MAX) ? LEN_MAX
                                  : r_line_length + LEN_W'(1);
                end
            end
        endcase
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_lock_mode   <= MODE_IDLE;
            r_mode_timer  <= '0;
            r_blink_timer <= '0;
            r_red_phase   <= 1'b1;
            r_digit_count <= '0;
            r_line_length <= '0;
            r_parse_phase <= PH_PREFIX;
            r_prefix_ok   <= 1'b1;
            r_old_length  <= '0;
            r_old_matches <= 1'b1;
            r_new_length  <= '0;
            for (int i = 0; i < PIN_DIGITS; i++) begin
                r_stored_pin[i] <= default_pin_char(2'(i));
            end
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_lock_mode   <= n_lock_mode;
                r_mode_timer  <= n_mode_timer;
                r_blink_timer <= n_blink_timer;
                r_red_phase   <= n_red_phase;
                r_digit_count <= n_digit_count;
                r_line_length <= n_line_length;
                r_parse_phase <= n_parse_phase;
                r_prefix_ok   <= n_prefix_ok;
                r_old_length  <= n_old_length;
                r_old_matches <= n_old_matches;
                r_new_length  <= n_new_length;
                r_stored_pin  <= n_stored_pin;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_entered    <= n_entered;
            r_new_digits <= n_new_digits;
            r_out_data   <= {n_event, n_flash, (n_lock_mode == MODE_ACCESS),
                             n_red_phase, n_lock_mode};
        end
    end

`ifndef SYNTHESIS
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_count <= DC_LAST)
        else $error("digit count beyond PIN length");

    a_digits_only_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock_mode != MODE_AWAIT |-> r_digit_count == '0)
        else $error("digits held outside PIN entry");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_length <= LINE_LAST)
        else $error("serial line length beyond limit");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |=> r_in_valid && $stable(r_in_action))
        else $error("buffered item lost while output stalled");

    a_green_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[3] == (r_out_data[1:0] == MODE_ACCESS))
                        && !(r_out_data[3] && r_out_data[2]))
        else $error("indicator drive inconsistent with mode");
`endif

endmodule

/* test/keypad_code_lock_unit_checker.sv */
// Checker for the keypad code lock: watches both streams, predicts each result and compares.
module keypad_code_lock_unit_checker
    import kcl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [TIMER_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [15:0]        i_in_data,    // key_char[7:0], rx_byte[15:8]
    input  logic [1:0]         i_in_user,    // action[1:0]
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [15:0]        i_out_data,   // lock_mode_out[1:0], red_light[2],
                                             // green_light[3], key_flash[4],
                                             // event_code[8:5], zero[15:9]
    output int                 o_fail_count,
    output int                 o_pending,
    output logic [31:0]        o_pin         // stored PIN, first character in [7:0]
);

    localparam int NDIG = KCL_PIN_DIGITS;
    localparam int PRINT_CAP = 200;
    localparam logic [63:0] CMD_TEXT    = "NEW PIN;";
    localparam logic [31:0] FACTORY_PIN = "1772";

    typedef struct packed {
        logic [3:0] event_code;
        logic       key_flash;
        logic       green;
        logic       red;
        logic [1:0] mode;
    } t_lock_result;

    // timing settings
    logic [TIMER_W-1:0] input_timeout, access_time, blink_half;

    // lock state
    logic [1:0]         lock_mode;
    logic [TIMER_W-1:0] mode_timer, blink_timer;
    logic               red_phase;
    logic [2:0]         digit_count;
    t_char              entered [NDIG];
    t_char              pin [NDIG];

    // serial line parser state
    logic [LEN_W-1:0]   line_len, old_len, new_len;
    logic [1:0]         parse_phase;
    logic               prefix_ok, old_ok;
    t_char              new_dig [NDIG];

    t_lock_result       expected_q [$];
    int                 fail_n = 0;
    int                 result_n = 0;
    int                 pending_n = 0;
    logic [31:0]        pin_n = FACTORY_PIN;

    assign o_fail_count = fail_n;
    assign o_pending    = pending_n;
    assign o_pin        = pin_n;

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        fail_n++;
        // keep the log short when the block is badly off
        if (fail_n <= PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_n, what, got_v, want_v);
    endtask

    task automatic enter_mode(input logic [1:0] m);
        lock_mode   = m;
        mode_timer  = '0;
        blink_timer = '0;
        digit_count = '0;
        red_phase   = (m != MODE_ACCESS);
    endtask

    task automatic restart_line();
        line_len    = '0;
        parse_phase = PH_PREFIX;
        prefix_ok   = 1'b1;
        old_len     = '0;
        old_ok      = 1'b1;
        new_len     = '0;
    endtask

    task automatic advance_lock(input logic [1:0] act, input t_char key, input t_char rx,
                                output t_lock_result res);
        logic [3:0] ev;
        logic       flash;
        logic       same;
        int         i;
        ev    = EV_NONE;
        flash = 1'b0;
        case (act)
            ACT_TICK: begin
                if (lock_mode == MODE_AWAIT) begin
                    if (mode_timer != TIMER_MAX) mode_timer++;
                    if (blink_timer != TIMER_MAX) blink_timer++;
                    // blink toggle is settled before the timeout
                    if (blink_timer >= blink_half) begin
                        blink_timer = '0;
                        red_phase   = ~red_phase;
                    end
                    if (mode_timer >= input_timeout) begin
                        enter_mode(MODE_IDLE);
                        ev = EV_TIMEOUT;
                    end
                end else if (lock_mode == MODE_ACCESS) begin
                    if (mode_timer != TIMER_MAX) mode_timer++;
                    if (mode_timer >= access_time) begin
                        enter_mode(MODE_IDLE);
                        ev = EV_SESSION_END;
                    end
                end
            end
            ACT_BUTTON: begin
                if (lock_mode == MODE_IDLE) begin
                    enter_mode(MODE_AWAIT);
                    ev = EV_AWAIT;
                end
            end
            ACT_KEY: begin
                if (lock_mode == MODE_AWAIT) begin
                    flash = 1'b1;
                    if (digit_count < NDIG) entered[digit_count] = key;
                    digit_count++;
                    if (digit_count >= NDIG) begin
                        same = 1'b1;
                        for (i = 0; i < NDIG; i++)
                            if (entered[i] != pin[i]) same = 1'b0;
                        if (same) begin
                            enter_mode(MODE_ACCESS);
                            ev = EV_GRANTED;
                        end else begin
                            enter_mode(MODE_IDLE);
                            ev = EV_WRONG_PIN;
                        end
                    end
                end
            end
            default: begin
                if (rx == CH_CR || rx == CH_LF) begin
                    // empty lines are dropped silently
                    if (line_len != 0) begin
                        if (lock_mode != MODE_IDLE) ev = EV_NOT_IDLE;
                        else if (parse_phase == PH_PREFIX || !prefix_ok) ev = EV_UNKNOWN_CMD;
                        else if (parse_phase != PH_NEW) ev = EV_BAD_FORMAT;
                        else if (old_len != NDIG || new_len != NDIG) ev = EV_WRONG_LENGTH;
                        else if (!old_ok) ev = EV_OLD_PIN_BAD;
                        else begin
                            pin = new_dig;
                            ev  = EV_PIN_UPDATED;
                        end
                        restart_line();
                    end
                end else if (line_len >= KCL_LINE_MAX - 1) begin
                    restart_line();
                    ev = EV_LINE_LONG;
                end else begin
                    case (parse_phase)
                        PH_PREFIX: begin
                            if (rx != CMD_TEXT[63 - 8*line_len[2:0] -: 8]) prefix_ok = 1'b0;
                            if (line_len + 1 >= PREFIX_LEN) parse_phase = PH_OLD;
                        end
                        PH_OLD: begin
                            // first separator after the prefix splits old from new
                            if (rx == CH_SEMI) begin
                                parse_phase = PH_NEW;
                            end else begin
                                if (old_len < NDIG && rx != pin[old_len]) old_ok = 1'b0;
                                if (old_len != LEN_MAX) old_len++;
                            end
                        end
                        default: begin
                            if (new_len < NDIG) new_dig[new_len] = rx;
                            if (new_len != LEN_MAX) new_len++;
                        end
                    endcase
                    if (line_len != LEN_MAX) line_len++;
                end
            end
        endcase
        res.mode       = lock_mode;
        res.red        = red_phase;
        res.green      = (lock_mode == MODE_ACCESS);
        res.key_flash  = flash;
        res.event_code = ev;
    endtask

    always @(posedge i_clk) begin
        t_lock_result want;
        t_lock_result got;
        int           i;
        if (!i_rst_n) begin
            input_timeout = RST_INPUT_TIMEOUT;
            access_time   = RST_ACCESS_TIME;
            blink_half    = RST_BLINK_HALF;
            enter_mode(MODE_IDLE);
            restart_line();
            for (i = 0; i < NDIG; i++) begin
                pin[i]     = FACTORY_PIN[31 - 8*(i % 4) -: 8];
                entered[i] = '0;
                new_dig[i] = '0;
            end
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = t_lock_result'(i_out_data[8:0]);
                if (expected_q.size() == 0) begin
                    report_mismatch("result with none expected, data", got, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.mode != want.mode)
                        report_mismatch("lock mode", got.mode, want.mode);
                    if (got.red != want.red)
                        report_mismatch("red light", got.red, want.red);
                    if (got.green != want.green)
                        report_mismatch("green light", got.green, want.green);
                    if (got.key_flash != want.key_flash)
                        report_mismatch("key flash", got.key_flash, want.key_flash);
                    if (got.event_code != want.event_code)
                        report_mismatch("event code", got.event_code, want.event_code);
                end
                result_n++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INPUT_TIMEOUT: input_timeout = i_cfg_data;
                    CFG_ACCESS_TIME:   access_time   = i_cfg_data;
                    CFG_BLINK_HALF:    blink_half    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_lock(i_in_user, i_in_data[7:0], i_in_data[15:8], want);
                expected_q.push_back(want);
            end
        end
        pending_n <= expected_q.size();
        for (i = 0; i < 4; i++) pin_n[8*i +: 8] <= pin[i];
    end

endmodule

/* test/keypad_code_lock_unit_test.sv */
// Testbench top for the keypad code lock: stimulus, timing settings, flow control and verdict.
module keypad_code_lock_unit_test;
    import kcl_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RUN_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int SEGMENTS     = 8;
    localparam int MAX_GAP      = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int SLOW_TIMEOUT = 96;
    localparam int SLOW_ACCESS  = 64;
    localparam int SLOW_BLINK   = 16;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;
    typedef enum logic [3:0] {
        LN_GOOD, LN_OLD_WRONG, LN_OLD_LEN, LN_NEW_LEN, LN_NO_SEP,
        LN_BAD_PREFIX, LN_SHORT, LN_TOO_LONG, LN_ZERO_BYTE, LN_SEMI_IN_NEW
    } t_line_kind;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_INPUT_TIMEOUT;
    logic [TIMER_W-1:0] i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;   // key_char[7:0], rx_byte[15:8]
    logic [1:0]         s_axis_tuser = ACT_TICK;   // action[1:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;        // lock_mode_out[1:0], red_light[2],
                                             // green_light[3], key_flash[4],
                                             // event_code[8:5], zero[15:9]

    int                 fail_count;
    int                 pending;
    logic [31:0]        pin_now;

    int                 tx_pct = 0;
    int                 rx_pct = 0;
    int                 cur_timeout = RST_INPUT_TIMEOUT;
    int                 cur_access = RST_ACCESS_TIME;
    int                 items_sent = 0;
    int                 random_items = 0;
    int                 unlock_tries = 0;
    int                 pin_lines = 0;
    int                 cycle_count = 0;
    logic               hold_req = 1'b0;
    logic               hold_done = 1'b0;
    int                 hold_left = 0;

    keypad_code_lock_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    keypad_code_lock_unit_checker lock_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pin        (pin_now)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_pct);
        end
    end

    function automatic t_char rand_byte();
        return t_char'($urandom_range(0, 255));
    endfunction

    // PIN characters: mostly digits, never a line end or a separator
    function automatic t_char pin_byte();
        t_char b;
        if ($urandom_range(0, 99) < 70) return t_char'(8'h30 + $urandom_range(0, 9));
        b = rand_byte();
        while (b == CH_CR || b == CH_LF || b == CH_SEMI) b = rand_byte();
        return b;
    endfunction

    // ticks after an entry: mostly just enough to run the timer out
    function automatic int tail_ticks(input int span);
        return ($urandom_range(0, 99) < 70) ? span + 1 : $urandom_range(0, span + 2);
    endfunction

    task automatic send_item(input logic [1:0] act, input t_char b);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < tx_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= (act == ACT_SERIAL) ? {b, rand_byte()} : {rand_byte(), b};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_item(ACT_TICK, rand_byte());
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timing(input int t_in, input int t_acc, input int t_blink);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INPUT_TIMEOUT;
        i_cfg_data <= TIMER_W'(t_in);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ACCESS_TIME;
        i_cfg_data <= TIMER_W'(t_acc);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BLINK_HALF;
        i_cfg_data <= TIMER_W'(t_blink);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_timeout = t_in;
        cur_access  = t_acc;
    endtask

    // button, four keys (one wrong unless right), then some ticks
    task automatic try_unlock(input bit right, input int pause_pct, input int tail);
        t_char code [4];
        t_char key;
        int    bad_pos;
        int    i;
        unlock_tries++;
        send_item(ACT_BUTTON, rand_byte());
        // the PIN seen here already covers every item before the button
        for (i = 0; i < 4; i++) code[i] = pin_now[8*i +: 8];
        bad_pos = right ? -1 : $urandom_range(0, 3);
        for (i = 0; i < 4; i++) begin
            if ($urandom_range(0, 99) < pause_pct) tick_run($urandom_range(1, 3));
            key = code[i];
            if (i == bad_pos)
                key = $urandom_range(0, 1) ? code[i] ^ (8'h01 << $urandom_range(0, 7))
                                           : rand_byte();
            send_item(ACT_KEY, key);
        end
        tick_run(tail);
    endtask

    initial begin
        int         seg;
        int         seg_end;
        int         start;
        int         pick;
        int         n;
        int         i;
        int         spot;
        int         directed_items;
        int         long_items;
        t_line_kind kind;
        t_char      line_bytes [$];
        t_char      code [4];
        t_char      b;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored items, empty lines, wrong and right PIN, command while busy
        send_item(ACT_TICK, 8'hA5);
        send_item(ACT_KEY, 8'h5A);
        send_item(ACT_SERIAL, CH_CR);
        send_item(ACT_SERIAL, CH_LF);
        send_item(ACT_BUTTON, 8'h00);
        send_item(ACT_BUTTON, 8'hFF);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_KEY, 8'h00);
        send_item(ACT_KEY, 8'hFF);
        send_item(ACT_KEY, "7");
        send_item(ACT_KEY, "2");
        send_item(ACT_BUTTON, 8'h00);
        send_item(ACT_KEY, "1");
        send_item(ACT_KEY, "7");
        send_item(ACT_KEY, "7");
        send_item(ACT_KEY, "2");
        send_item(ACT_KEY, "1");
        send_item(ACT_BUTTON, 8'h00);
        send_item(ACT_SERIAL, 8'hFF);
        send_item(ACT_SERIAL, 8'h00);
        send_item(ACT_SERIAL, CH_CR);
        wait_drained();
        directed_items = items_sent;

        // slow timers: the open session runs out, then entry times out, then access ends
        set_timing(SLOW_TIMEOUT, SLOW_ACCESS, SLOW_BLINK);
        tick_run(SLOW_ACCESS);
        send_item(ACT_BUTTON, rand_byte());
        tick_run(SLOW_TIMEOUT);
        try_unlock(1'b1, 0, SLOW_ACCESS);
        wait_drained();
        long_items = items_sent - directed_items;

        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       set_timing(30, 20, 4);
                1:       set_timing(1, 1, 1);
                2:       set_timing(0, 0, 0);
                4:       set_timing(40, 30, 8191);
                6:       set_timing(2, 3, 1);
                default: set_timing($urandom_range(1, 40), $urandom_range(1, 40),
                                    $urandom_range(1, 12));
            endcase
            case (t_idle_mode'(seg % 4))
                IDLE_NONE: begin tx_pct = 0;  rx_pct = 0;  end
                IDLE_TX:   begin tx_pct = 62; rx_pct = 0;  end
                IDLE_RX:   begin tx_pct = 0;  rx_pct = 62; end
                default:   begin tx_pct = 18; rx_pct = 18; end
            endcase
            // one long output hold-off while the input keeps being offered
            if (seg == 0) hold_req <= 1'b1;
            seg_end = random_items + RANDOM_ITEMS / SEGMENTS;
            while (random_items < seg_end) begin
                start = items_sent;
                pick  = $urandom_range(0, 99);
                if (pick < 35) begin
                    try_unlock($urandom_range(0, 99) < 60, 30, tail_ticks(cur_access));
                end else if (pick < 65) begin
                    pin_lines++;
                    kind = ($urandom_range(0, 99) < 40) ? LN_GOOD
                         : t_line_kind'($urandom_range(0, LN_SEMI_IN_NEW));
                    line_bytes.delete();
                    for (i = 0; i < PREFIX_LEN; i++) line_bytes.push_back(prefix_char(3'(i)));
                    if (kind == LN_BAD_PREFIX) begin
                        i = $urandom_range(0, PREFIX_LEN - 1);
                        line_bytes[i] = line_bytes[i] ^ (8'h01 << $urandom_range(0, 7));
                    end
                    if (kind == LN_SHORT) begin
                        n = $urandom_range(1, PREFIX_LEN - 1);
                        while (line_bytes.size() > n) b = line_bytes.pop_back();
                    end
                    send_item(ACT_SERIAL, line_bytes.pop_front());
                    for (i = 0; i < 4; i++) code[i] = pin_now[8*i +: 8];
                    if (kind != LN_SHORT) begin
                        n = (kind == LN_OLD_LEN) ? ($urandom_range(0, 1) ? 3 : 5)
                          : (kind == LN_TOO_LONG) ? $urandom_range(40, 56) : 4;
                        spot = $urandom_range(0, 3);
                        for (i = 0; i < n; i++) begin
                            b = (i < 4) ? code[i] : pin_byte();
                            if (kind == LN_OLD_WRONG && i == spot)
                                b = b ^ (8'h01 << $urandom_range(0, 7));
                            line_bytes.push_back(b);
                        end
                        if (kind != LN_NO_SEP) line_bytes.push_back(CH_SEMI);
                        n = 4;
                        if (kind == LN_NEW_LEN) begin
                            n = $urandom_range(0, 7);
                            if (n >= 4) n++;
                        end
                        for (i = 0; i < n; i++)
                            line_bytes.push_back((kind == LN_ZERO_BYTE && i == spot) ? 8'h00
                                                                                    : pin_byte());
                        // a separator inside the new part counts as a character
                        if (kind == LN_SEMI_IN_NEW) line_bytes.push_back(CH_SEMI);
                    end
                    case ($urandom_range(0, 2))
                        0:       line_bytes.push_back(CH_CR);
                        1:       line_bytes.push_back(CH_LF);
                        default: begin
                            line_bytes.push_back(CH_CR);
                            line_bytes.push_back(CH_LF);
                        end
                    endcase
                    while (line_bytes.size() != 0) send_item(ACT_SERIAL, line_bytes.pop_front());
                end else if (pick < 80) begin
                    // entry left to time out, with the red light blinking
                    send_item(ACT_BUTTON, rand_byte());
                    n = $urandom_range(0, 3);
                    for (i = 0; i < n; i++) send_item(ACT_KEY, rand_byte());
                    tick_run(tail_ticks(cur_timeout));
                end else begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        send_item(2'($urandom_range(0, 3)), rand_byte());
                end
                random_items += items_sent - start;
            end
            wait_drained();
        end

        $display("covered %0d items: %0d directed, %0d on the slow timers, %0d random",
                 items_sent, directed_items, long_items, random_items);
        $display("%0d timing settings incl. zero and 8191, %0d unlock tries, %0d PIN lines",
                 SEGMENTS + 2, unlock_tries, pin_lines);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
